/* hdl/vtpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package vtpd_pkg;

    localparam int COEF_FRAC_BITS  = 12;
    localparam int COORD_FRAC_BITS = 16;

    localparam int COEF_W    = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = COEF_W + COORD_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int REM_W     = ACC_W + 1;
    localparam int QUO_W     = COORD_W;
    localparam int INT_W     = COORD_W - COORD_FRAC_BITS;
    localparam int NUM_COMP  = 3;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [31:0] CFG_RESET [NUM_REGS] = '{
        32'h0000_1000, 32'h0000_0000, 32'h1000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 32'h1000_0000
    };

    // One word in flight through the divider. In vector mode q already holds
    // the finished value and ovf its clamp flag; the divider steps leave it alone.
    typedef struct packed {
        logic [ACC_W-1:0]                 d;
        logic                             point;
        logic                             dz;
        logic [NUM_COMP-1:0]              neg;
        logic [NUM_COMP-1:0]              ovf;
        logic [NUM_COMP-1:0][REM_W-1:0]   rem;
        logic [NUM_COMP-1:0][QUO_W-1:0]   lo;
        logic [NUM_COMP-1:0][QUO_W-1:0]   q;
    } div_t;

endpackage
`default_nettype wire

/* hdl/vtpd_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
module vtpd_divider (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire vtpd_pkg::div_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output vtpd_pkg::div_t      out_data
);
    import vtpd_pkg::*;

    // One restoring quotient bit per stage, for all three components at once.
    function automatic div_t div_step(input div_t x);
        div_t             y;
        logic [REM_W-1:0] t;
        logic             qbit;
        y = x;
        for (int i = 0; i < NUM_COMP; i++) begin
            t    = {x.rem[i][REM_W-2:0], x.lo[i][QUO_W-1]};
            qbit = (t >= {1'b0, x.d});
            if (x.point) begin
                y.rem[i] = qbit ? (t - {1'b0, x.d}) : t;
                y.lo[i]  = {x.lo[i][QUO_W-2:0], 1'b0};
                y.q[i]   = {x.q[i][QUO_W-2:0], qbit};
            end
        end
        return y;
    endfunction

    logic [QUO_W-1:0] vld_reg;
    logic [QUO_W:0]   rdy;
    div_t             stg_reg [QUO_W];

    assign rdy[QUO_W] = out_ready;
    assign in_ready   = rdy[0];
    assign out_valid  = vld_reg[QUO_W-1];
    assign out_data   = stg_reg[QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                stg_reg[k] <= div_step((k == 0) ? in_data : stg_reg[(k == 0) ? 0 : k-1]);
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/vertex_transform_perspective_divide.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per cycle unless the output stalls; the 32-stage quotient
// pipeline sets the depth. Every stage holds its word while the stage after it
// is full and cannot move on, so bubbles fill.
// Reset (aresetn low at a clock edge) empties the pipeline and loads the
// identity matrix into the coefficient registers.
module vertex_transform_perspective_divide (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // in_x, in_y, in_z
    input  wire logic [0:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // out_x, out_y, out_z
    output logic [1:0]       m_tuser,   // divide_by_zero, saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);
    import vtpd_pkg::*;

    // Coefficient registers. Register colC_rowsAB carries row A in the low
    // half and row B in the high half. Writes beyond the last index are dropped.
    logic [31:0] cfg_reg [NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) cfg_reg[i] <= CFG_RESET[i];
        end else if (cfg_valid && !cfg_index[CFG_IDX_W-1]) begin
            cfg_reg[cfg_index[CFG_IDX_W-2:0]] <= cfg_data;
        end
    end

    logic signed [COEF_W-1:0] coef_m [4][4];   // [column][row]
    for (genvar c = 0; c < 4; c++) begin : g_col
        for (genvar r = 0; r < 4; r++) begin : g_row
            assign coef_m[c][r] = cfg_reg[c*2 + r/2][(r%2)*COEF_W +: COEF_W];
        end
    end

    // Handshake chain: each stage takes a new word when it is empty or when
    // the stage after it moves on in the same cycle.
    logic v1_reg, v2_reg, v3_reg, out_rdy, s1_rdy, s2_rdy, s3_rdy;
    logic div_in_ready, div_out_valid;

    assign out_rdy  = !m_tvalid || m_tready;
    assign s3_rdy   = !v3_reg || div_in_ready;
    assign s2_rdy   = !v2_reg || s3_rdy;
    assign s1_rdy   = !v1_reg || s2_rdy;
    assign s_tready = s1_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s1_rdy) v1_reg <= s_tvalid;
            if (s2_rdy) v2_reg <= v1_reg;
            if (s3_rdy) v3_reg <= v2_reg;
        end
    end

    // Stage 1: the twelve coefficient-by-coordinate products. The w column is
    // only a shift of the translation coefficient, so it needs no multiplier.
    logic signed [COORD_W-1:0] vin [NUM_COMP];
    logic signed [PROD_W-1:0]  prod_next [4][NUM_COMP];
    logic signed [PROD_W-1:0]  prod_reg  [4][NUM_COMP];
    logic signed [COEF_W-1:0]  t3_reg [4];
    logic                      point1_reg;

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) vin[c] = s_tdata[c*COORD_W +: COORD_W];
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < NUM_COMP; c++) begin
                prod_next[r][c] = coef_m[c][r] * vin[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy) begin
            prod_reg   <= prod_next;
            point1_reg <= s_tuser[0];
            for (int r = 0; r < 4; r++) t3_reg[r] <= s_tuser[0] ? coef_m[3][r] : '0;
        end
    end

    // Stage 2: exact row sums at the combined fraction scale.
    logic signed [ACC_W-1:0] acc_next [4];
    logic signed [ACC_W-1:0] acc_reg  [4];
    logic                    point2_reg;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            acc_next[r] = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                        + ACC_W'(prod_reg[r][2])
                        + (ACC_W'(t3_reg[r]) <<< COORD_FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_rdy) begin
            acc_reg    <= acc_next;
            point2_reg <= point1_reg;
        end
    end

    // Stage 3: vector mode rounds and clamps here. Point mode takes
    // magnitudes, checks ahead whether the quotient fits 32 bits, and seeds
    // the long division with the integer-sized top of the numerator.
    logic [ACC_W-1:0]         dmag;
    logic [ACC_W-1:0]         nmag [NUM_COMP];
    logic signed [ACC_W:0]    vsum [NUM_COMP];
    logic signed [ACC_W:0]    vshift [NUM_COMP];
    logic                     vsat [NUM_COMP];
    div_t                     div_next, div_in_reg, div_out;

    always_comb begin
        dmag = acc_reg[3][ACC_W-1] ? ACC_W'(-acc_reg[3]) : ACC_W'(acc_reg[3]);
        div_next       = '0;
        div_next.d     = dmag;
        div_next.point = point2_reg;
        div_next.dz    = (acc_reg[3] == '0);
        for (int r = 0; r < NUM_COMP; r++) begin
            nmag[r]   = acc_reg[r][ACC_W-1] ? ACC_W'(-acc_reg[r]) : ACC_W'(acc_reg[r]);
            vsum[r]   = (ACC_W+1)'(acc_reg[r]) + ((ACC_W+1)'(1) <<< (COEF_FRAC_BITS-1));
            vshift[r] = vsum[r] >>> COEF_FRAC_BITS;
            vsat[r]   = !((&vshift[r][ACC_W:COORD_W-1]) || !(|vshift[r][ACC_W:COORD_W-1]));
            if (point2_reg) begin
                div_next.neg[r] = acc_reg[r][ACC_W-1] ^ acc_reg[3][ACC_W-1];
                div_next.ovf[r] = {{INT_W{1'b0}}, nmag[r]} >= {dmag, {INT_W{1'b0}}};
                div_next.rem[r] = REM_W'(nmag[r] >> INT_W);
                div_next.lo[r]  = {nmag[r][INT_W-1:0], {COORD_FRAC_BITS{1'b0}}};
            end else begin
                div_next.ovf[r] = vsat[r];
                div_next.q[r]   = vsat[r] ? (vshift[r][ACC_W] ? COORD_MIN : COORD_MAX)
                                          : vshift[r][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_rdy) div_in_reg <= div_next;
    end

    vtpd_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3_reg),
        .in_ready  (div_in_ready),
        .in_data   (div_in_reg),
        .out_valid (div_out_valid),
        .out_ready (out_rdy),
        .out_data  (div_out)
    );

    // Output stage: sign, clamp and the zero-w case, then the output register.
    logic [COORD_W-1:0] res [NUM_COMP];
    logic [NUM_COMP-1:0] rsat;
    logic [95:0] tdata_next;
    logic [1:0]  tuser_next;

    always_comb begin
        for (int r = 0; r < NUM_COMP; r++) begin
            if (!div_out.point) begin
                res[r]  = div_out.q[r];
                rsat[r] = div_out.ovf[r];
            end else if (div_out.dz) begin
                res[r]  = '0;
                rsat[r] = 1'b0;
            end else if (div_out.ovf[r]) begin
                res[r]  = div_out.neg[r] ? COORD_MIN : COORD_MAX;
                rsat[r] = 1'b1;
            end else if (!div_out.neg[r]) begin
                rsat[r] = div_out.q[r][QUO_W-1];
                res[r]  = rsat[r] ? COORD_MAX : div_out.q[r];
            end else begin
                rsat[r] = div_out.q[r] > COORD_MIN;
                res[r]  = rsat[r] ? COORD_MIN : (-div_out.q[r]);
            end
        end
        tdata_next = {res[2], res[1], res[0]};
        tuser_next = {|rsat, div_out.point && div_out.dz};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_rdy) begin
            m_tvalid <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) begin
            m_tdata <= tdata_next;
            m_tuser <= tuser_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/vtpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module vtpd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // A zero w gives zero coordinates.
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 96'd0)
        else $error("divide by zero with nonzero coordinates");

    // A zero w never reports a clamp.
    a_dz_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("divide by zero flagged together with saturation");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/tb_vertex_transform_perspective_divide.sv */
`timescale 1ns / 1ps
`default_nettype none

// Expected-result store for the transform. Each accepted vertex is run through
// a behavioral model of the matrix multiply and divide, and every output word
// is compared against the oldest prediction still waiting.
class vertex_scoreboard;
    logic [31:0] coef_regs [vtpd_pkg::NUM_REGS];
    logic [97:0] pending_q [$];
    int          error_count;

    function new();
        for (int i = 0; i < vtpd_pkg::NUM_REGS; i++) coef_regs[i] = vtpd_pkg::CFG_RESET[i];
        error_count = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
        if (idx < vtpd_pkg::NUM_REGS) coef_regs[idx] = value;
    endfunction

    function longint coef(int col, int row);
        logic [31:0] r;
        logic [15:0] h;
        r = coef_regs[(col << 1) | (row >> 1)];
        h = (row & 1) ? r[31:16] : r[15:0];
        return longint'($signed(h));
    endfunction

    function logic [31:0] clamp(longint v, inout bit sat);
        if (v > 64'sh7FFF_FFFF) begin
            sat = 1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Truncated fixed-point quotient with saturation on an oversized integer part.
    function logic [31:0] divide(longint num, longint den, inout bit sat);
        longint unsigned n, d, q, r;
        bit neg;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        q = n / d;
        r = n % d;
        if ((q >> (32 - vtpd_pkg::COORD_FRAC_BITS)) != 0) begin
            sat = 1;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        for (int i = 0; i < vtpd_pkg::COORD_FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return clamp(neg ? -longint'(q) : longint'(q), sat);
    endfunction

    function void note_vertex(logic point, logic [95:0] coords);
        longint v [4];
        longint acc [4];
        logic [31:0] res [3];
        bit sat, dz;
        sat = 0;
        dz = 0;
        for (int c = 0; c < 3; c++) v[c] = longint'($signed(coords[32*c +: 32]));
        v[3] = point ? (64'sd1 << vtpd_pkg::COORD_FRAC_BITS) : 0;
        for (int r = 0; r < 4; r++) begin
            acc[r] = 0;
            for (int c = 0; c < 4; c++) acc[r] += coef(c, r) * v[c];
        end
        for (int r = 0; r < 3; r++) res[r] = '0;
        if (!point) begin
            for (int r = 0; r < 3; r++)
                res[r] = clamp((acc[r] + (64'sd1 << (vtpd_pkg::COEF_FRAC_BITS - 1)))
                               >>> vtpd_pkg::COEF_FRAC_BITS, sat);
        end else if (acc[3] == 0) begin
            dz = 1;
        end else begin
            for (int r = 0; r < 3; r++) res[r] = divide(acc[r], acc[3], sat);
        end
        pending_q.push_back({sat, dz, res[2], res[1], res[0]});
    endfunction

    function void check_result(logic [95:0] data, logic [1:0] flags);
        logic [97:0] exp_word;
        if (pending_q.size() == 0) begin
            $error("unexpected output word %h flags %b", data, flags);
            error_count++;
            return;
        end
        exp_word = pending_q.pop_front();
        if (data[31:0] !== exp_word[31:0]) begin
            $error("out_x expected %h actual %h", exp_word[31:0], data[31:0]);
            error_count++;
        end
        if (data[63:32] !== exp_word[63:32]) begin
            $error("out_y expected %h actual %h", exp_word[63:32], data[63:32]);
            error_count++;
        end
        if (data[95:64] !== exp_word[95:64]) begin
            $error("out_z expected %h actual %h", exp_word[95:64], data[95:64]);
            error_count++;
        end
        if (flags[0] !== exp_word[96]) begin
            $error("divide_by_zero expected %b actual %b", exp_word[96], flags[0]);
            error_count++;
        end
        if (flags[1] !== exp_word[97]) begin
            $error("saturated expected %b actual %b", exp_word[97], flags[1]);
            error_count++;
        end
    endfunction
endclass

module tb_vertex_transform_perspective_divide;
    import vtpd_pkg::*;

    localparam int PIPE_LATENCY = 36;
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    vertex_scoreboard expected_vertices = new();

    // Idle probability in percent for each side; zero gives full-rate stretches.
    int  sender_idle_pct = 31;
    int  receiver_idle_pct = 31;
    // Set while the receiver should hold off entirely so the pipeline backs up.
    bit  hold_receiver = 0;
    int  cycle_count = 0;

    always #6 aclk = ~aclk;

    vertex_transform_perspective_divide u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: every accepted output word is checked at the edge, then m_tready
    // is chosen for the next cycle. The long hold-off is counted in the block below.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) expected_vertices.check_result(m_tdata, m_tuser);
        if (!aresetn || hold_receiver) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    initial begin
        wait (hold_receiver);
        repeat (200) @(posedge aclk);
        hold_receiver = 0;
    end

    // Sends one vertex word, with a random number of idle cycles before it.
    // The valid line stays high between words sent back to back.
    task automatic send_vertex(logic point, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {z, y, x};
        s_tuser  <= point;
        do @(posedge aclk); while (!s_tready);
        expected_vertices.note_vertex(point, {z, y, x});
    endtask

    task automatic write_coef(int idx, logic [31:0] value);
        cfg_valid <= 1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        expected_vertices.write_reg(idx, value);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // Waits until every prediction has been matched, then lets the pipeline drain.
    task automatic drain_pipeline();
        s_tvalid <= 0;
        while (expected_vertices.pending_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    // Mostly moderate coordinates, so divides stay in range, with some full-range values.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(200000000)) - 100000000);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        if ($urandom_range(3) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(16384)) - 8192);
    endfunction

    task automatic random_matrix();
        logic [15:0] w3;
        for (int i = 0; i < 8; i++) write_coef(i, {rand_coef(), rand_coef()});
        // Often make the w row a plain affine one so points divide cleanly.
        if ($urandom_range(1)) begin
            w3 = 16'(16'h1000 + ($urandom_range(511) - 256));
            write_coef(1, {16'h0000, $urandom_range(1) ? 16'h0000 : rand_coef()});
            write_coef(3, {16'h0000, rand_coef()});
            write_coef(5, {16'h0000, rand_coef()});
            write_coef(7, {w3, rand_coef()});
        end
    endtask

    task automatic random_vertices(int count);
        for (int i = 0; i < count; i++) send_vertex($urandom_range(1), rand_coord(),
                                                    rand_coord(), rand_coord());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed vertices under the identity matrix: extremes of each field.
        send_vertex(1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000);
        send_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_vertex(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_vertex(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_vertex(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
        drain_pipeline();

        // Matrix with zero w row: points hit the divide-by-zero case.
        for (int i = 0; i < 8; i++) write_coef(i, (i & 1) ? 32'h0000_7FFF : 32'h8000_7FFF);
        send_vertex(1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        drain_pipeline();

        // All coefficients at the largest magnitudes, then a tiny w giving huge quotients.
        for (int i = 0; i < 8; i++) write_coef(i, 32'h8000_8000);
        send_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(1'b1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        drain_pipeline();
        for (int i = 0; i < 8; i++) write_coef(i, (i == 7) ? 32'h0001_7FFF : 32'h7FFF_7FFF);
        send_vertex(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_vertex(1'b1, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0001);
        send_vertex(1'b0, 32'h0000_0800, 32'hFFFF_F800, 32'h0000_0000);
        drain_pipeline();

        // Random phases. One runs at full rate with the receiver held off.
        for (int phase = 0; phase < 8; phase++) begin
            random_matrix();
            if (phase == 2) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
                hold_receiver = 1;
            end else begin
                sender_idle_pct = 31;
                receiver_idle_pct = 31;
            end
            random_vertices(110);
            drain_pipeline();
        end

        if (expected_vertices.error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
